>>> hdl/ffba_pkg.sv
`timescale 1ns / 1ps

package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 12;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = IDX_W + 1;

    localparam int ADDR_W   = 32;
    localparam int USABLE_W = 24;
    localparam int SIZE_W   = 24;
    localparam int WANT_W   = SIZE_W + 1;
    localparam int LEN_W    = 25;
    localparam int SUM_W    = USABLE_W + 2;
    localparam int STAT_W   = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [ADDR_W-1:0]   HDR_ADDR   = ADDR_W'(HEADER_BYTES);
    localparam logic [USABLE_W-1:0] USABLE_MAX = {USABLE_W{1'b1}};

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OOM      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_BLOCK = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RSVD     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LENGTH = 1'b1;

    localparam logic [ADDR_W-1:0] HEAP_BASE_RST   = 32'h0010_0000;
    localparam logic [LEN_W-1:0]  HEAP_LENGTH_RST = 25'h030_0000;

    typedef struct packed {
        logic [ADDR_W-1:0]   start;
        logic [USABLE_W-1:0] usable;
        logic                is_free;
    } ffba_entry_t;

    localparam int ENTRY_W = $bits(ffba_entry_t);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_NEXT_RD,
        ST_NEXT_CHK,
        ST_SHIFT,
        ST_WR_NEW,
        ST_WR_HIT,
        ST_RESP
    } ffba_state_t;

    // round up to a multiple of 4
    function automatic logic [WANT_W-1:0] round_size(input logic [SIZE_W-1:0] size);
        logic [WANT_W-1:0] sum;
        begin
            sum = {1'b0, size} + WANT_W'(3);
            return {sum[WANT_W-1:2], 2'b00};
        end
    endfunction

    function automatic logic [USABLE_W-1:0] usable_of_length(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] diff;
        begin
            diff = len - LEN_W'(HEADER_BYTES);
            if (len < LEN_W'(HEADER_BYTES)) begin
                return '0;
            end else if (diff > {1'b0, USABLE_MAX}) begin
                return USABLE_MAX;
            end else begin
                return diff[USABLE_W-1:0];
            end
        end
    endfunction

    function automatic logic [USABLE_W-1:0] merge_usable(input logic [USABLE_W-1:0] a,
                                                         input logic [USABLE_W-1:0] b);
        logic [SUM_W-1:0] sum;
        begin
            sum = {2'b00, a} + {2'b00, b} + SUM_W'(HEADER_BYTES);
            return (sum > {2'b00, USABLE_MAX}) ? USABLE_MAX : sum[USABLE_W-1:0];
        end
    endfunction

endpackage

>>> hdl/ffba_ram.sv
`timescale 1ns / 1ps

module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/first_fit_block_allocator_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Contents
// s_        in   s_tvalid/s_tready    tdata: request_size, block_address; tuser: kind
// m_        out  m_tvalid/m_tready    tdata: granted_address; tuser: status
// cfg_      in   cfg_wr_en            cfg_index selects heap_base or heap_length
//
// One request at a time through a single-port-pair block table RAM. The table scan
// reads one entry a cycle until a hit or the end of the live entries. A split moves
// the entries above the hit up one slot, then writes the new free entry and the hit;
// a free reads the next entry and, if it is free, merges it and moves the entries
// above it down one slot. After reset and after every register write the table is
// rebuilt as one free block. A finished result waits in the output register; the next
// word is taken meanwhile, and the block stalls only if a second result is ready.

module first_fit_block_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // [23:0] request_size, [55:24] block_address
    input  logic [0:0]  s_tuser,   // [0] kind

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] granted_address
    output logic [1:0]  m_tuser,   // [1:0] status

    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int IDX_W = ffba_pkg::IDX_W;
    localparam int CNT_W = ffba_pkg::CNT_W;

    ffba_pkg::ffba_state_t state_reg, state_next;

    logic [CNT_W-1:0]                count_reg, count_next;
    logic [CNT_W-1:0]                scan_reg, scan_next;
    logic                            pend_reg, pend_next;
    logic [IDX_W-1:0]                pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]                hit_idx_reg, hit_idx_next;
    ffba_pkg::ffba_entry_t           hit_reg, hit_next;
    ffba_pkg::ffba_entry_t           new_reg, new_next;
    logic                            merge_reg, merge_next;
    logic                            sh_up_reg, sh_up_next;
    logic [CNT_W-1:0]                sh_src_reg, sh_src_next;
    logic                            sh_pend_reg, sh_pend_next;
    logic [IDX_W-1:0]                sh_pend_idx_reg, sh_pend_idx_next;
    logic                            kind_reg, kind_next;
    logic [ffba_pkg::WANT_W-1:0]     want_reg, want_next;
    logic [ffba_pkg::ADDR_W-1:0]     addr_reg, addr_next;
    logic [ffba_pkg::ADDR_W-1:0]     res_addr_reg, res_addr_next;
    logic [ffba_pkg::STAT_W-1:0]     res_status_reg, res_status_next;
    logic                            m_valid_reg, m_valid_next;
    logic [ffba_pkg::ADDR_W-1:0]     m_addr_reg, m_addr_next;
    logic [ffba_pkg::STAT_W-1:0]     m_status_reg, m_status_next;
    logic [ffba_pkg::ADDR_W-1:0]     heap_base_reg, heap_base_next;
    logic [ffba_pkg::LEN_W-1:0]      heap_length_reg, heap_length_next;

    logic                            ram_we;
    logic [IDX_W-1:0]                ram_waddr;
    ffba_pkg::ffba_entry_t           ram_wdata;
    logic [IDX_W-1:0]                ram_raddr;
    ffba_pkg::ffba_entry_t           ram_rdata;

    logic                            hit_found;
    logic                            split_ok;
    logic                            sh_issue;
    logic [ffba_pkg::SUM_W-1:0]      split_need;

    ffba_ram #(
        .WIDTH(ffba_pkg::ENTRY_W),
        .DEPTH(ffba_pkg::MAX_BLOCKS)
    ) u_table (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    assign s_tready = (state_reg == ffba_pkg::ST_IDLE) && !cfg_wr_en;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_addr_reg;
    assign m_tuser  = m_status_reg;

    // shared compare on the entry just read
    assign split_need = {1'b0, want_reg} + ffba_pkg::SUM_W'(ffba_pkg::HEADER_BYTES + 4);
    assign split_ok   = ({2'b00, ram_rdata.usable} >= split_need) &&
                        (count_reg < CNT_W'(ffba_pkg::MAX_BLOCKS));
    assign hit_found  = (kind_reg == ffba_pkg::KIND_ALLOC)
                        ? (ram_rdata.is_free && ({1'b0, ram_rdata.usable} >= want_reg))
                        : ((ram_rdata.start + ffba_pkg::HDR_ADDR) == addr_reg);
    assign sh_issue   = sh_up_reg ? (sh_src_reg > {1'b0, hit_idx_reg})
                                  : (sh_src_reg < count_reg);

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        scan_next        = scan_reg;
        pend_next        = pend_reg;
        pend_idx_next    = pend_idx_reg;
        hit_idx_next     = hit_idx_reg;
        hit_next         = hit_reg;
        new_next         = new_reg;
        merge_next       = merge_reg;
        sh_up_next       = sh_up_reg;
        sh_src_next      = sh_src_reg;
        sh_pend_next     = sh_pend_reg;
        sh_pend_idx_next = sh_pend_idx_reg;
        kind_next        = kind_reg;
        want_next        = want_reg;
        addr_next        = addr_reg;
        res_addr_next    = res_addr_reg;
        res_status_next  = res_status_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_addr_next      = m_addr_reg;
        m_status_next    = m_status_reg;
        heap_base_next   = heap_base_reg;
        heap_length_next = heap_length_reg;
        ram_we           = 1'b0;
        ram_waddr        = hit_idx_reg;
        ram_wdata        = hit_reg;
        ram_raddr        = scan_reg[IDX_W-1:0];

        unique case (state_reg)
            ffba_pkg::ST_INIT: begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = '{start:   heap_base_reg,
                               usable:  ffba_pkg::usable_of_length(heap_length_reg),
                               is_free: 1'b1};
                count_next = CNT_W'(1);
                state_next = ffba_pkg::ST_IDLE;
            end

            ffba_pkg::ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    kind_next       = s_tuser[0];
                    want_next       = ffba_pkg::round_size(s_tdata[23:0]);
                    addr_next       = s_tdata[55:24];
                    scan_next       = '0;
                    pend_next       = 1'b0;
                    merge_next      = 1'b0;
                    res_addr_next   = '0;
                    res_status_next = ffba_pkg::STAT_OK;
                    if ((s_tuser[0] == ffba_pkg::KIND_FREE) && (s_tdata[55:24] == '0)) begin
                        state_next = ffba_pkg::ST_RESP;
                    end else begin
                        state_next = ffba_pkg::ST_SCAN;
                    end
                end
            end

            ffba_pkg::ST_SCAN: begin
                if (pend_reg && hit_found) begin
                    hit_idx_next = pend_idx_reg;
                    pend_next    = 1'b0;
                    sh_pend_next = 1'b0;
                    hit_next     = ram_rdata;
                    if (kind_reg == ffba_pkg::KIND_ALLOC) begin
                        hit_next.is_free = 1'b0;
                        res_addr_next    = ram_rdata.start + ffba_pkg::HDR_ADDR;
                        if (split_ok) begin
                            hit_next.usable = want_reg[ffba_pkg::USABLE_W-1:0];
                            new_next = '{start:   ram_rdata.start + ffba_pkg::HDR_ADDR
                                                  + ffba_pkg::ADDR_W'(want_reg),
                                         usable:  ram_rdata.usable
                                                  - want_reg[ffba_pkg::USABLE_W-1:0]
                                                  - ffba_pkg::USABLE_W'(ffba_pkg::HEADER_BYTES),
                                         is_free: 1'b1};
                            sh_up_next  = 1'b1;
                            sh_src_next = count_reg - CNT_W'(1);
                            state_next  = ffba_pkg::ST_SHIFT;
                        end else begin
                            state_next = ffba_pkg::ST_WR_HIT;
                        end
                    end else begin
                        hit_next.is_free = 1'b1;
                        if (({1'b0, pend_idx_reg} + CNT_W'(1)) < count_reg) begin
                            state_next = ffba_pkg::ST_NEXT_RD;
                        end else begin
                            state_next = ffba_pkg::ST_WR_HIT;
                        end
                    end
                end else if (scan_reg < count_reg) begin
                    // issue the next entry read
                    ram_raddr     = scan_reg[IDX_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        res_status_next = (kind_reg == ffba_pkg::KIND_ALLOC)
                                          ? ffba_pkg::STAT_OOM : ffba_pkg::STAT_NO_BLOCK;
                        state_next      = ffba_pkg::ST_RESP;
                    end
                end
            end

            ffba_pkg::ST_NEXT_RD: begin
                ram_raddr  = hit_idx_reg + IDX_W'(1);
                state_next = ffba_pkg::ST_NEXT_CHK;
            end

            ffba_pkg::ST_NEXT_CHK: begin
                if (ram_rdata.is_free) begin
                    merge_next      = 1'b1;
                    hit_next.usable = ffba_pkg::merge_usable(hit_reg.usable, ram_rdata.usable);
                end
                state_next = ffba_pkg::ST_WR_HIT;
            end

            ffba_pkg::ST_SHIFT: begin
                // write back the entry read last cycle, one slot up or down
                if (sh_pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = sh_up_reg ? (sh_pend_idx_reg + IDX_W'(1))
                                          : (sh_pend_idx_reg - IDX_W'(1));
                    ram_wdata = ram_rdata;
                end
                if (sh_issue) begin
                    ram_raddr        = sh_src_reg[IDX_W-1:0];
                    sh_pend_next     = 1'b1;
                    sh_pend_idx_next = sh_src_reg[IDX_W-1:0];
                    sh_src_next      = sh_up_reg ? (sh_src_reg - CNT_W'(1))
                                                 : (sh_src_reg + CNT_W'(1));
                end else begin
                    sh_pend_next = 1'b0;
                    if (!sh_pend_reg) begin
                        if (sh_up_reg) begin
                            state_next = ffba_pkg::ST_WR_NEW;
                        end else begin
                            count_next = count_reg - CNT_W'(1);
                            state_next = ffba_pkg::ST_RESP;
                        end
                    end
                end
            end

            ffba_pkg::ST_WR_NEW: begin
                ram_we     = 1'b1;
                ram_waddr  = hit_idx_reg + IDX_W'(1);
                ram_wdata  = new_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = ffba_pkg::ST_WR_HIT;
            end

            ffba_pkg::ST_WR_HIT: begin
                ram_we    = 1'b1;
                ram_waddr = hit_idx_reg;
                ram_wdata = hit_reg;
                if (merge_reg) begin
                    sh_up_next   = 1'b0;
                    sh_src_next  = {1'b0, hit_idx_reg} + CNT_W'(2);
                    sh_pend_next = 1'b0;
                    state_next   = ffba_pkg::ST_SHIFT;
                end else begin
                    state_next = ffba_pkg::ST_RESP;
                end
            end

            ffba_pkg::ST_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_addr_next   = res_addr_reg;
                    m_status_next = res_status_reg;
                    state_next    = ffba_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = ffba_pkg::ST_INIT;
            end
        endcase

        // a register write rebuilds the table
        if (cfg_wr_en) begin
            unique case (cfg_index)
                ffba_pkg::CFG_HEAP_BASE:   heap_base_next   = cfg_wdata;
                ffba_pkg::CFG_HEAP_LENGTH: heap_length_next = cfg_wdata[ffba_pkg::LEN_W-1:0];
                default:                   heap_base_next   = heap_base_reg;
            endcase
            state_next = ffba_pkg::ST_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ffba_pkg::ST_INIT;
            count_reg       <= CNT_W'(1);
            pend_reg        <= 1'b0;
            sh_pend_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
            heap_base_reg   <= ffba_pkg::HEAP_BASE_RST;
            heap_length_reg <= ffba_pkg::HEAP_LENGTH_RST;
        end else begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            pend_reg        <= pend_next;
            sh_pend_reg     <= sh_pend_next;
            m_valid_reg     <= m_valid_next;
            heap_base_reg   <= heap_base_next;
            heap_length_reg <= heap_length_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg        <= scan_next;
        pend_idx_reg    <= pend_idx_next;
        hit_idx_reg     <= hit_idx_next;
        hit_reg         <= hit_next;
        new_reg         <= new_next;
        merge_reg       <= merge_next;
        sh_up_reg       <= sh_up_next;
        sh_src_reg      <= sh_src_next;
        sh_pend_idx_reg <= sh_pend_idx_next;
        kind_reg        <= kind_next;
        want_reg        <= want_next;
        addr_reg        <= addr_next;
        res_addr_reg    <= res_addr_next;
        res_status_reg  <= res_status_next;
        m_addr_reg      <= m_addr_next;
        m_status_reg    <= m_status_next;
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(1)) && (count_reg <= CNT_W'(ffba_pkg::MAX_BLOCKS)))
        else $error("block count out of range");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !cfg_wr_en) |=> (state_reg != ffba_pkg::ST_IDLE))
        else $error("accepted word did not start work");

    a_write_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ({1'b0, ram_waddr} <= count_reg))
        else $error("table write beyond live entries");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_status_reg != ffba_pkg::STAT_RSVD))
        else $error("reserved status code on output");

endmodule
